// ===== hdl/running_median_two_heaps_core_macros.svh =====
// Assertion macros shared by the running median RTL.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_CORE_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define RM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define RM_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RM_ASSERT(label, clk, rst_n, prop)
`define RM_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== hdl/rmh_pkg.sv =====
// Package with shared constants for the running median core.
package rmh_pkg;
	localparam int SampleW = 32;
	localparam int MedW = 33;
	localparam int CountW = 11;
endpackage

// ===== hdl/rmh_ram.sv =====
// Generic single-port RAM with registered read.
module rmh_ram #(
	parameter int Width = 32,
	parameter int Depth = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write on we; read registered, giving the old data on a write to the same address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== hdl/running_median_two_heaps_core.sv =====
// Top level of the running median core built on two heaps.
//
// Usage:
//   The s_axis channel takes one signed 32-bit sample per item. For each
//   accepted item the m_axis channel gives one result item: twice the
//   median (one fractional bit), the number of held samples, and a flag
//   that marks a sample dropped because the store was full.
//   One sequencer and one compare unit walk the heaps held in two
//   single-port RAMs; each heap access sets the address, then takes the data.
//   From the accepting edge the result is registered after the tops are
//   read and the heap walk is done: a sift-up for an insert, and a
//   sift-down before that push when a top is replaced. The next item is
//   taken only after that result is registered, so the core does not take
//   a new sample while one is in flight; s_axis_tready is low meanwhile.
//   The result is held in an output register until m_axis_tready; the
//   next item is accepted while that result waits.
//   Reset clears both counts; heap contents are not cleared.
//   A stalled receiver blocks completion of the next item only.
module running_median_two_heaps_core #(
	parameter int HEAP_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // [32:0] median_doubled, [43:33] sample_count,
	                                   // [44] dropped_full, [47:45] zero
);
	import rmh_pkg::*;
`include "running_median_two_heaps_core_macros.svh"

	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int TW = $clog2(2 * HEAP_DEPTH + 1);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_TOPS = 4'd1, ST_TOPW = 4'd2,
		ST_DEC = 4'd3, ST_UPRD = 4'd4, ST_UPW = 4'd5, ST_UPCMP = 4'd6,
		ST_DNL = 4'd7, ST_DNLW = 4'd8, ST_DNR = 4'd9, ST_DNRW = 4'd10,
		ST_DNCMP = 4'd11, ST_DNW = 4'd12, ST_RES = 4'd13, ST_RESW = 4'd14,
		ST_OUT = 4'd15;

	logic [3:0] state_q;
	logic [CW-1:0] lcnt_q, ucnt_q;
	logic signed [SampleW-1:0] x_q, ltop_q, utop_q, cur_q, other_q, best_v_q, moved_q;
	logic [AW-1:0] pos_q, best_q;
	logic [CW-1:0] n_q;
	logic heap_q;      // 1: lower (max) heap, 0: upper (min) heap
	logic push2_q;     // a push to the other heap follows
	logic drop_q;
	logic out_v_q;
	logic [47:0] out_q;
	logic out_fire;

	// RAM ports, one address for whichever heap is active.
	logic l_we, u_we;
	logic [AW-1:0] ram_addr;
	logic [SampleW-1:0] ram_wdata, l_rd, u_rd, rd;
	assign rd = heap_q ? l_rd : u_rd;

	rmh_ram #(.Width(SampleW), .Depth(HEAP_DEPTH)) u_lower (
		.clk(clk), .we(l_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(l_rd));
	rmh_ram #(.Width(SampleW), .Depth(HEAP_DEPTH)) u_upper (
		.clk(clk), .we(u_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(u_rd));

	// Shared compare unit: a outranks b in the active heap's order.
	logic signed [SampleW-1:0] cmp_a, cmp_b;
	logic outr;
	assign outr = heap_q ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

	logic [AW-1:0] parent, lchild, rchild;
	logic [AW:0] l_full;
	assign parent = AW'((pos_q - 1'b1) >> 1);
	assign l_full = {pos_q, 1'b1};
	assign lchild = l_full[AW-1:0];
	assign rchild = AW'(l_full + 1'b1);

	logic [TW-1:0] total;
	assign total = TW'(lcnt_q) + TW'(ucnt_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_q;
	assign out_fire = (state_q == ST_OUT) && (!out_v_q || m_axis_tready);

	// Memory control, driven from the current step.
	always_comb begin
		l_we = 1'b0;
		u_we = 1'b0;
		ram_addr = pos_q;
		ram_wdata = cur_q;
		cmp_a = cur_q;
		cmp_b = rd;
		case (state_q)
			ST_TOPS, ST_RES: ram_addr = '0;
			ST_UPRD: ram_addr = parent;
			ST_UPW, ST_DNW: begin
				l_we = heap_q;
				u_we = !heap_q;
				ram_addr = pos_q;
				ram_wdata = (state_q == ST_UPW) ? other_q : best_v_q;
			end
			ST_DNL: ram_addr = lchild;
			ST_DNR: ram_addr = rchild;
			ST_DNLW: begin
				cmp_a = rd;
				cmp_b = cur_q;
			end
			ST_DNRW: begin
				cmp_a = rd;
				cmp_b = best_v_q;
			end
			default: ;
		endcase
	end

	// Output valid: set when a result is registered, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_fire) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lcnt_q <= '0;
			ucnt_q <= '0;
			heap_q <= 1'b1;
			push2_q <= 1'b0;
			drop_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					x_q <= s_axis_tdata;
					drop_q <= 1'b0;
					state_q <= ST_TOPS;
				end
				ST_TOPS: state_q <= ST_TOPW;
				ST_TOPW: begin
					ltop_q <= l_rd;
					utop_q <= u_rd;
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (total >= TW'(2 * HEAP_DEPTH)) begin
						drop_q <= 1'b1;
						state_q <= ST_RES;
					end else if (lcnt_q == '0 || x_q <= ltop_q) begin
						heap_q <= 1'b1;
						if (lcnt_q == ucnt_q) begin
							pos_q <= AW'(lcnt_q);
							cur_q <= x_q;
							other_q <= x_q;
							lcnt_q <= lcnt_q + 1'b1;
							state_q <= ST_UPW;
						end else begin
							moved_q <= ltop_q;
							push2_q <= 1'b1;
							pos_q <= '0;
							cur_q <= x_q;
							n_q <= lcnt_q;
							state_q <= ST_DNL;
						end
					end else if (lcnt_q > ucnt_q) begin
						heap_q <= 1'b0;
						pos_q <= AW'(ucnt_q);
						cur_q <= x_q;
						other_q <= x_q;
						ucnt_q <= ucnt_q + 1'b1;
						state_q <= ST_UPW;
					end else if (ucnt_q == '0 || x_q <= utop_q) begin
						heap_q <= 1'b1;
						pos_q <= AW'(lcnt_q);
						cur_q <= x_q;
						other_q <= x_q;
						lcnt_q <= lcnt_q + 1'b1;
						state_q <= ST_UPW;
					end else begin
						heap_q <= 1'b0;
						moved_q <= utop_q;
						push2_q <= 1'b1;
						pos_q <= '0;
						cur_q <= x_q;
						n_q <= ucnt_q;
						state_q <= ST_DNL;
					end
				end
				// Sift-up: other_q is written at pos, then parent compared.
				ST_UPW: begin
					if (pos_q == '0) begin
						state_q <= ST_RES;
					end else begin
						state_q <= ST_UPRD;
					end
				end
				ST_UPRD: state_q <= ST_UPCMP;
				ST_UPCMP: begin
					if (outr) begin
						// write parent's value at pos, then cur at parent
						best_q <= parent;
						best_v_q <= rd;
						state_q <= ST_DNW;
					end else begin
						state_q <= ST_RES;
					end
				end
				// Sift-down: read both children, pick best.
				ST_DNL: begin
					best_q <= pos_q;
					best_v_q <= cur_q;
					if (l_full >= (AW + 1)'(n_q)) begin
						state_q <= ST_DNW;
					end else begin
						state_q <= ST_DNLW;
					end
				end
				ST_DNLW: begin
					if (outr) begin
						best_q <= lchild;
						best_v_q <= rd;
					end
					state_q <= ST_DNR;
				end
				ST_DNR: begin
					if ((AW + 1)'(l_full + 1'b1) >= (AW + 1)'(n_q)) begin
						state_q <= ST_DNCMP;
					end else begin
						state_q <= ST_DNRW;
					end
				end
				ST_DNRW: begin
					if (outr) begin
						best_q <= rchild;
						best_v_q <= rd;
					end
					state_q <= ST_DNCMP;
				end
				ST_DNCMP: state_q <= ST_DNW;
				// Shared write: best value goes to pos, cur moves to best.
				ST_DNW: begin
					if (best_q == pos_q) begin
						// final write of cur at pos done here; push the moved top or finish
						if (push2_q) begin
							push2_q <= 1'b0;
							heap_q <= !heap_q;
							cur_q <= moved_q;
							other_q <= moved_q;
							if (heap_q) begin
								pos_q <= AW'(ucnt_q);
								ucnt_q <= ucnt_q + 1'b1;
							end else begin
								pos_q <= AW'(lcnt_q);
								lcnt_q <= lcnt_q + 1'b1;
							end
							state_q <= ST_UPW;
						end else begin
							state_q <= ST_RES;
						end
					end else begin
						pos_q <= best_q;
						if (best_q < pos_q) begin
							other_q <= cur_q;
							state_q <= ST_UPW;
						end else begin
							state_q <= ST_DNL;
						end
					end
				end
				ST_RES: state_q <= ST_RESW;
				ST_RESW: begin
					ltop_q <= l_rd;
					utop_q <= u_rd;
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_fire) begin
					if (lcnt_q == '0) begin
						out_q[32:0] <= '0;
					end else if (lcnt_q == ucnt_q) begin
						out_q[32:0] <= MedW'(ltop_q) + MedW'(utop_q);
					end else begin
						out_q[32:0] <= {ltop_q, 1'b0};
					end
					out_q[43:33] <= CountW'(total);
					out_q[44] <= drop_q;
					out_q[47:45] <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`RM_ASSERT(a_cnt_bal, clk, arst_n, (lcnt_q == ucnt_q) || (lcnt_q == ucnt_q + 1'b1) || (state_q != ST_IDLE))
	`RM_ASSERT(a_cnt_max, clk, arst_n, (lcnt_q <= CW'(HEAP_DEPTH)) && (ucnt_q <= CW'(HEAP_DEPTH)))
	`RM_ASSERT(a_out_hold, clk, arst_n, (out_v_q && !m_axis_tready) |=> out_v_q)
endmodule

// ===== dv/running_median_two_heaps_core_tb.sv =====
// Self-checking testbench for the two-heap running median core.
`timescale 1ns / 1ps

module running_median_two_heaps_core_tb;
	import rmh_pkg::*;

	localparam int Depth = 512;
	localparam int Capacity = 2 * Depth;
	localparam int RandomItems = 1050;
	localparam int WatchdogLimit = 20000;
	localparam int HoldOffCycles = 600;

	// Expected result of one item.
	typedef struct packed {
		logic [MedW-1:0] median_doubled;
		logic [CountW-1:0] sample_count;
		logic dropped_full;
	} median_result_t;

	// Directed stimulus row; has_value marks a result typed in by hand.
	typedef struct {
		logic [SampleW-1:0] sample;
		bit has_value;
		median_result_t value;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;

	// Predictor state: a sorted copy of all held samples.
	int held_samples[$];
	median_result_t expected_results[$];
	int mismatch_count;
	int result_count;
	int dropped_count;
	int stall_cycles;
	bit idle_enable;
	bit hold_off;
	bit stim_done;

	running_median_two_heaps_core #(.HEAP_DEPTH(Depth)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Adds one sample to the held set and returns the median result.
	function automatic median_result_t compute_median(logic signed [SampleW-1:0] x);
		median_result_t r;
		int n;
		int pos;
		longint lo;
		longint hi;
		r.dropped_full = 1'b0;
		if (held_samples.size() >= Capacity) begin
			r.dropped_full = 1'b1;
		end else begin
			pos = 0;
			while (pos < held_samples.size() && held_samples[pos] < int'(x))
				pos++;
			held_samples.insert(pos, int'(x));
		end
		n = held_samples.size();
		// Lower half holds the extra element when the count is odd.
		lo = held_samples[(n - 1) / 2];
		hi = (n % 2 == 1) ? lo : longint'(held_samples[n / 2]);
		r.median_doubled = MedW'(lo + hi);
		r.sample_count = CountW'(n);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
			result_count, what, got, want);
		mismatch_count++;
	endtask

	// Sends one item and queues its predicted result.
	task automatic send_sample(logic [SampleW-1:0] x, bit has_value, median_result_t value);
		median_result_t predicted;
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= x;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predicted = compute_median(x);
		if (has_value && predicted != value)
			report_mismatch("directed prediction", predicted, value);
		expected_results.push_back(predicted);
		@(negedge clk);
	endtask

	// Receiver: random stall bursts, one long hold-off when asked.
	initial begin
		m_axis_tready = 1'b0;
		stall_cycles = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
			end else if (stall_cycles > 0) begin
				stall_cycles--;
				m_axis_tready <= 1'b0;
			end else if (idle_enable && $urandom_range(0, 4) == 0) begin
				stall_cycles = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Long hold-off: counted here while the sender keeps offering items.
	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (3000) @(posedge clk);
		hold_off = 1'b1;
		repeat (HoldOffCycles) @(posedge clk);
		hold_off = 1'b0;
	end

	// Result checker.
	always @(posedge clk) begin
		median_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, 0);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[32:0] !== want.median_doubled)
					report_mismatch("median_doubled", m_axis_tdata[32:0], want.median_doubled);
				if (m_axis_tdata[43:33] !== want.sample_count)
					report_mismatch("sample_count", m_axis_tdata[43:33], want.sample_count);
				if (m_axis_tdata[44] !== want.dropped_full)
					report_mismatch("dropped_full", m_axis_tdata[44], want.dropped_full);
				if (m_axis_tdata[47:45] !== 3'b000)
					report_mismatch("padding", m_axis_tdata[47:45], 0);
				if (want.dropped_full)
					dropped_count++;
			end
			result_count++;
		end
	end

	// Watchdog on cycles without any handshake.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
				quiet = 0;
			else if (!stim_done || expected_results.size() > 0)
				quiet++;
			if (quiet >= WatchdogLimit) begin
				$display("watchdog expired with %0d results pending", expected_results.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Main stimulus.
	initial begin
		stim_row_t rows[$];
		median_result_t none;
		int wait_cycles;
		int mode;
		logic [SampleW-1:0] x;
		none = '0;
		mismatch_count = 0;
		result_count = 0;
		dropped_count = 0;
		idle_enable = 1'b0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: extremes, odd and even counts, both heaps' branches.
		rows.push_back('{32'h8000_0000, 1'b1, '{33'h1_0000_0000, 11'd1, 1'b0}});
		rows.push_back('{32'h7fff_ffff, 1'b1, '{33'h1_ffff_ffff, 11'd2, 1'b0}});
		rows.push_back('{32'h0000_0000, 1'b1, '{33'h0, 11'd3, 1'b0}});
		rows.push_back('{32'h7fff_ffff, 1'b1, '{33'h0_7fff_ffff, 11'd4, 1'b0}});
		rows.push_back('{32'h7fff_ffff, 1'b1, '{33'h0_ffff_fffe, 11'd5, 1'b0}});
		rows.push_back('{32'hffff_ffff, 1'b0, none});
		rows.push_back('{32'h8000_0000, 1'b0, none});
		rows.push_back('{32'h0000_0001, 1'b0, none});
		rows.push_back('{32'h5555_5555, 1'b0, none});
		rows.push_back('{32'haaaa_aaaa, 1'b0, none});
		rows.push_back('{32'h0000_0001, 1'b0, none});
		rows.push_back('{32'hffff_fffe, 1'b0, none});
		rows.push_back('{32'h1234_5678, 1'b0, none});
		rows.push_back('{32'hedcb_a988, 1'b0, none});
		foreach (rows[i])
			send_sample(rows[i].sample, rows[i].has_value, rows[i].value);

		// Random part; mostly small values so duplicates and ties happen.
		idle_enable = 1'b1;
		for (int i = 0; i < RandomItems; i++) begin
			mode = $urandom_range(0, 3);
			case (mode)
				0: x = $urandom;
				1: x = SampleW'($signed($urandom_range(0, 40)) - 20);
				2: x = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
				default: x = $urandom_range(0, 1) ? $urandom_range(0, 1000) : -$urandom_range(0, 1000);
			endcase
			// Last stretch runs without idling.
			if (i == RandomItems - 60)
				idle_enable = 1'b0;
			send_sample(x, 1'b0, none);
		end
		s_axis_tvalid <= 1'b0;
		stim_done = 1'b1;

		wait_cycles = 0;
		while (expected_results.size() > 0 && wait_cycles < WatchdogLimit) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);

		$display("Run covered %0d results, %0d of them dropped with the store full.",
			result_count, dropped_count);
		$display("Held samples at the end: %0d of %0d.", held_samples.size(), Capacity);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
